[sv/text_mode_cell_renderer_top_defines.svh]
// Assertion macros shared by the text-mode cell renderer modules.
// No dependencies; taken in by `include where assertions are written.
`ifndef TEXT_MODE_CELL_RENDERER_TOP_DEFINES_SVH
`define TEXT_MODE_CELL_RENDERER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define TMCR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("tmcr assertion failed");
// antecedent in one cycle implies consequent in the next
`define TMCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("tmcr assertion failed");
`else
`define TMCR_ASSERT(lbl, clk, rstn, prop)
`define TMCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[sv/tmcr_pkg.sv]
// Shared types, constants and helpers for the text-mode cell renderer.
// No dependencies.
package tmcr_pkg;

	// glyph store bases
	localparam logic [13:0] BASE_N8  = 14'd0;
	localparam logic [13:0] BASE_D8  = 14'd2048;
	localparam logic [13:0] BASE_N16 = 14'd4096;
	localparam logic [13:0] BASE_D16 = 14'd8192;
	localparam logic [13:0] BASE_IT  = 14'd12288;

	localparam logic [7:0] DEC_BIAS    = 8'h5F;
	localparam logic [7:0] SOLID_ROW   = 8'hFF;
	localparam logic [7:0] COLS_NARROW = 8'd40;
	localparam logic [7:0] COLS_WIDE   = 8'd80;

	// rows within a cell
	localparam logic [3:0] LAST_NARROW = 4'd7;
	localparam logic [3:0] LAST_WIDE   = 4'd15;
	localparam logic [3:0] ULR_NARROW  = 4'd5;
	localparam logic [3:0] ULR_WIDE    = 4'd13;
	localparam logic [3:0] STR_NARROW  = 4'd4;
	localparam logic [3:0] STR_WIDE    = 4'd8;
	localparam logic [3:0] CUR_UL_WIDE = 4'd14;

	// cursor shapes
	localparam logic [2:0] SHP_BLOCK_BLINK  = 3'd1;
	localparam logic [2:0] SHP_BLOCK_STEADY = 3'd2;
	localparam logic [2:0] SHP_UL_BLINK     = 3'd3;
	localparam logic [2:0] SHP_UL_STEADY    = 3'd4;
	localparam logic [2:0] SHP_BAR_BLINK    = 3'd5;
	localparam logic [2:0] SHP_BAR_STEADY   = 3'd6;

	// register indexes
	typedef enum logic [2:0] {
		REG_WIDE   = 3'd0,
		REG_OFFSET = 3'd1,
		REG_CCOL   = 3'd2,
		REG_CROW   = 3'd3,
		REG_CON    = 3'd4,
		REG_CSHAPE = 3'd5,
		REG_CRGB   = 3'd6
	} reg_idx_t;

	// cursor action on one cell
	typedef enum logic [2:0] {
		CUR_NONE,
		CUR_BLOCK,
		CUR_FILL,
		CUR_BAR1,
		CUR_BAR2
	} cur_act_t;

	typedef struct packed {
		logic       wide;
		logic [8:0] line_offset;
		logic [7:0] cursor_col;
		logic [5:0] cursor_row;
		logic       cursor_on;
		logic [2:0] cursor_shape;
	} cfg_t;

	// classified item, front to back
	typedef struct packed {
		logic        is_write;
		logic        addr_ok;
		logic [13:0] addr;
		logic [7:0]  wbyte;
		logic        solid;
		logic [15:0] fg;
		logic [15:0] bg;
		cur_act_t    cur;
	} desc_t;

	function automatic logic [15:0] color_mask(input int bits);
		logic [16:0] m;
		m = (17'd1 << bits) - 17'd1;
		if (bits >= 16) begin
			return 16'hFFFF;
		end
		return m[15:0];
	endfunction

endpackage

[sv/text_mode_cell_renderer_top.sv]
// Top level of the text-mode cell renderer: ports, configuration registers,
// front end, descriptor queue and back end. Depends on tmcr_pkg and all tmcr_ modules.
//
// Channel  Handshake          Payload
// -------  -----------------  ------------------------------------------------
// in       in_valid/in_ready  op, scanline, column, glyph_code, attr_bits,
//                             colours, store_addr, store_byte, blink_half,
//                             cursor_shown
// out      out_valid/out_ready pixel_0 .. pixel_7 (one item per render)
// cfg      APB write/read     seven registers at 4*index, pready tied high
//
// One item is accepted per clock when nothing stalls; a render passes the queue, the
// glyph store read and the output register before out_valid, and a glyph store
// write lands as it leaves the queue. The rate is set by the glyph store, one read
// or one write a cycle, reads waiting while the output is held. A two-entry queue lets
// the front keep taking items while the output register waits. No clearing pass after
// reset: the glyph store is undefined until written, so the block is ready out of reset.
module text_mode_cell_renderer_top #(
	parameter int GLYPH_DEPTH = 16384,
	parameter int COLOR_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [8:0]  scanline,
	input  logic [6:0]  column,
	input  logic [7:0]  glyph_code,
	input  logic [7:0]  attr_bits,
	input  logic [15:0] fore_rgb,
	input  logic [15:0] back_rgb,
	input  logic [15:0] underline_rgb,
	input  logic [13:0] store_addr,
	input  logic [7:0]  store_byte,
	input  logic [1:0]  blink_half,
	input  logic        cursor_shown,
	// result items
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pixel_0,
	output logic [15:0] pixel_1,
	output logic [15:0] pixel_2,
	output logic [15:0] pixel_3,
	output logic [15:0] pixel_4,
	output logic [15:0] pixel_5,
	output logic [15:0] pixel_6,
	output logic [15:0] pixel_7,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [15:0] ColorMask = tmcr_pkg::color_mask(COLOR_BITS);

	tmcr_pkg::cfg_t   cfg_q;
	logic [15:0]      cursor_rgb_q;
	tmcr_pkg::reg_idx_t reg_idx;
	logic             cfg_wr, push, q_full, q_pop, q_valid;
	tmcr_pkg::desc_t  desc_in, desc_head;
	logic [7:0][15:0] pixels;

	// ---- configuration port ----
	assign pready  = 1'b1;
	assign reg_idx = tmcr_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q        <= '0;
			cursor_rgb_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				tmcr_pkg::REG_WIDE:   cfg_q.wide         <= pwdata[0];
				tmcr_pkg::REG_OFFSET: cfg_q.line_offset  <= pwdata[8:0];
				tmcr_pkg::REG_CCOL:   cfg_q.cursor_col   <= pwdata[7:0];
				tmcr_pkg::REG_CROW:   cfg_q.cursor_row   <= pwdata[5:0];
				tmcr_pkg::REG_CON:    cfg_q.cursor_on    <= pwdata[0];
				tmcr_pkg::REG_CSHAPE: cfg_q.cursor_shape <= pwdata[2:0];
				tmcr_pkg::REG_CRGB:   cursor_rgb_q       <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			tmcr_pkg::REG_WIDE:   prdata = 32'(cfg_q.wide);
			tmcr_pkg::REG_OFFSET: prdata = 32'(cfg_q.line_offset);
			tmcr_pkg::REG_CCOL:   prdata = 32'(cfg_q.cursor_col);
			tmcr_pkg::REG_CROW:   prdata = 32'(cfg_q.cursor_row);
			tmcr_pkg::REG_CON:    prdata = 32'(cfg_q.cursor_on);
			tmcr_pkg::REG_CSHAPE: prdata = 32'(cfg_q.cursor_shape);
			tmcr_pkg::REG_CRGB:   prdata = 32'(cursor_rgb_q);
			default:              prdata = 32'd0;
		endcase
	end

	// ---- front: classify ----
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	tmcr_front #(
		.GLYPH_DEPTH(GLYPH_DEPTH),
		.COLOR_BITS (COLOR_BITS)
	) u_front (
		.cfg          (cfg_q),
		.op           (op),
		.scanline     (scanline),
		.column       (column),
		.glyph_code   (glyph_code),
		.attr_bits    (attr_bits),
		.fore_rgb     (fore_rgb),
		.back_rgb     (back_rgb),
		.underline_rgb(underline_rgb),
		.store_addr   (store_addr),
		.store_byte   (store_byte),
		.blink_half   (blink_half),
		.cursor_shown (cursor_shown),
		.desc         (desc_in)
	);

	// ---- queue ----
	tmcr_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (desc_in),
		.full     (q_full),
		.pop      (q_pop),
		.dout     (desc_head),
		.not_empty(q_valid)
	);

	// ---- back: store access and paint ----
	tmcr_back #(
		.GLYPH_DEPTH(GLYPH_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (desc_head),
		.head_valid(q_valid),
		.pop       (q_pop),
		.ccol      (cursor_rgb_q & ColorMask),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixels    (pixels)
	);

	assign pixel_0 = pixels[0];
	assign pixel_1 = pixels[1];
	assign pixel_2 = pixels[2];
	assign pixel_3 = pixels[3];
	assign pixel_4 = pixels[4];
	assign pixel_5 = pixels[5];
	assign pixel_6 = pixels[6];
	assign pixel_7 = pixels[7];

endmodule

[sv/tmcr_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tmcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/tmcr_front.sv]
// Front end: classifies an accepted item into a descriptor for the back end.
// Depends on tmcr_pkg.
module tmcr_front #(
	parameter int GLYPH_DEPTH = 16384,
	parameter int COLOR_BITS  = 16
) (
	input  tmcr_pkg::cfg_t  cfg,
	input  logic            op,
	input  logic [8:0]      scanline,
	input  logic [6:0]      column,
	input  logic [7:0]      glyph_code,
	input  logic [7:0]      attr_bits,
	input  logic [15:0]     fore_rgb,
	input  logic [15:0]     back_rgb,
	input  logic [15:0]     underline_rgb,
	input  logic [13:0]     store_addr,
	input  logic [7:0]      store_byte,
	input  logic [1:0]      blink_half,
	input  logic            cursor_shown,
	output tmcr_pkg::desc_t desc
);

	localparam logic [15:0] ColorMask = tmcr_pkg::color_mask(COLOR_BITS);

	logic [8:0]  rel;
	logic [3:0]  srow, last, ulr, strr;
	logic [5:0]  trow;
	logic [7:0]  row_attr_mask, dec, cols, cx;
	logic        line_hit, ul_row, blink, wrap, steady, hit;
	logic [15:0] fg_m, bg_m, ul_m, fg_b;
	logic [13:0] g_addr, addr;
	logic [2:0]  shape;
	tmcr_pkg::cur_act_t cur;

	always_comb begin
		rel  = scanline - cfg.line_offset;
		srow = cfg.wide ? rel[3:0] : {1'b0, rel[2:0]};
		trow = cfg.wide ? {1'b0, rel[8:4]} : rel[8:3];
		last = cfg.wide ? tmcr_pkg::LAST_WIDE : tmcr_pkg::LAST_NARROW;
		ulr  = cfg.wide ? tmcr_pkg::ULR_WIDE : tmcr_pkg::ULR_NARROW;
		strr = cfg.wide ? tmcr_pkg::STR_WIDE : tmcr_pkg::STR_NARROW;

		ul_row        = (srow == last) || (srow == ulr);
		row_attr_mask = {2'b00, srow == 4'd0, srow == strr, ul_row, srow == last, 2'b00};
		line_hit      = |(attr_bits & row_attr_mask);
		blink         = |(attr_bits[1:0] & blink_half);

		fg_m = fore_rgb & ColorMask;
		bg_m = back_rgb & ColorMask;
		ul_m = underline_rgb & ColorMask;
		fg_b = blink ? bg_m : fg_m;

		// glyph row address
		dec = glyph_code - tmcr_pkg::DEC_BIAS;
		if (attr_bits[6]) begin
			g_addr = (cfg.wide ? tmcr_pkg::BASE_D16 : tmcr_pkg::BASE_D8)
				+ 14'({srow, 5'b0}) + 14'(dec[4:0]);
		end else if (cfg.wide && attr_bits[7] && !glyph_code[7]) begin
			g_addr = tmcr_pkg::BASE_IT + 14'({srow, 7'b0}) + 14'(glyph_code[6:0]);
		end else begin
			g_addr = (cfg.wide ? tmcr_pkg::BASE_N16 : tmcr_pkg::BASE_N8)
				+ 14'({srow, 8'b0}) + 14'(glyph_code);
		end
		addr = op ? store_addr : g_addr;

		// cursor; a pending wrap parks a block in the last column
		cols   = cfg.wide ? tmcr_pkg::COLS_WIDE : tmcr_pkg::COLS_NARROW;
		wrap   = cfg.cursor_col >= cols;
		cx     = wrap ? cols - 8'd1 : cfg.cursor_col;
		steady = (cfg.cursor_shape == tmcr_pkg::SHP_BLOCK_STEADY)
			|| (cfg.cursor_shape == tmcr_pkg::SHP_UL_STEADY)
			|| (cfg.cursor_shape == tmcr_pkg::SHP_BAR_STEADY);
		hit    = (trow == cfg.cursor_row) && cfg.cursor_on && (cursor_shown || steady)
			&& ({1'b0, column} == cx);
		shape  = wrap ? tmcr_pkg::SHP_BLOCK_BLINK : cfg.cursor_shape;
		unique case (shape)
			tmcr_pkg::SHP_UL_BLINK, tmcr_pkg::SHP_UL_STEADY: begin
				cur = ((srow == last) || (cfg.wide && srow == tmcr_pkg::CUR_UL_WIDE))
					? tmcr_pkg::CUR_FILL : tmcr_pkg::CUR_NONE;
			end
			tmcr_pkg::SHP_BAR_BLINK, tmcr_pkg::SHP_BAR_STEADY: begin
				cur = cfg.wide ? tmcr_pkg::CUR_BAR2 : tmcr_pkg::CUR_BAR1;
			end
			default: begin
				cur = tmcr_pkg::CUR_BLOCK;
			end
		endcase

		desc.is_write = op;
		desc.addr_ok  = int'(addr) < GLYPH_DEPTH;
		desc.addr     = addr;
		desc.wbyte    = store_byte;
		desc.solid    = line_hit;
		desc.fg       = (line_hit && ul_row) ? ul_m : fg_b;
		desc.bg       = bg_m;
		desc.cur      = hit ? cur : tmcr_pkg::CUR_NONE;
	end

endmodule

[sv/tmcr_fifo.sv]
// Two-entry descriptor queue between front and back ends.
// Depends on tmcr_pkg and text_mode_cell_renderer_top_defines.svh.
`include "text_mode_cell_renderer_top_defines.svh"
module tmcr_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tmcr_pkg::desc_t din,
	output logic            full,
	input  logic            pop,
	output tmcr_pkg::desc_t dout,
	output logic            not_empty
);

	tmcr_pkg::desc_t mem_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign dout      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	`TMCR_ASSERT(a_no_overflow, clk, arst_n, !(push && count_q == 2'd2 && !pop))
	`TMCR_ASSERT(a_no_underflow, clk, arst_n, !(pop && count_q == 2'd0))

endmodule

[sv/tmcr_back.sv]
// Back end: glyph store access, pixel painting and the output register.
// Depends on tmcr_pkg, tmcr_ram and text_mode_cell_renderer_top_defines.svh.
`include "text_mode_cell_renderer_top_defines.svh"
module tmcr_back #(
	parameter int GLYPH_DEPTH = 16384
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tmcr_pkg::desc_t    head,
	input  logic               head_valid,
	output logic               pop,
	input  logic [15:0]        ccol,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0][15:0]   pixels
);

	localparam int AW = $clog2(GLYPH_DEPTH);

	tmcr_pkg::desc_t desc_s1;
	logic            valid_s1, valid_s2;
	logic [7:0][15:0] pix_s2, pix_d;
	logic            out_free, s1_adv, ram_we, ram_re;
	logic [7:0]      rdata, bits;

	assign out_free = !valid_s2 || out_ready;
	assign s1_adv   = !valid_s1 || out_free;
	// store writes never wait; reads wait for room in stage 1
	assign pop      = head_valid && (head.is_write || s1_adv);
	assign ram_we   = pop && head.is_write && head.addr_ok;
	assign ram_re   = pop && !head.is_write;

	tmcr_ram #(
		.WIDTH(8),
		.DEPTH(GLYPH_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(head.addr)),
		.wdata(head.wbyte),
		.re   (ram_re),
		.raddr(AW'(head.addr)),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (ram_re) begin
			desc_s1 <= head;
		end
		if (valid_s1 && out_free) begin
			pix_s2 <= pix_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_adv) begin
				valid_s1 <= ram_re;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_comb begin
		bits = desc_s1.addr_ok ? rdata : 8'h00;
		if (desc_s1.solid) begin
			bits = tmcr_pkg::SOLID_ROW;
		end
		for (int i = 0; i < 8; i++) begin
			pix_d[i] = bits[7-i] ? desc_s1.fg : desc_s1.bg;
			unique case (desc_s1.cur)
				tmcr_pkg::CUR_BLOCK: pix_d[i] = bits[7-i] ? desc_s1.bg : ccol;
				tmcr_pkg::CUR_FILL:  pix_d[i] = ccol;
				tmcr_pkg::CUR_BAR1: begin
					if (i == 0) begin
						pix_d[i] = ccol;
					end
				end
				tmcr_pkg::CUR_BAR2: begin
					if (i < 2) begin
						pix_d[i] = ccol;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = valid_s2;
	assign pixels    = pix_s2;

	`TMCR_ASSERT_NEXT(a_rdata_held, clk, arst_n, valid_s1 && !out_free, $stable(rdata))
	`TMCR_ASSERT(a_one_access, clk, arst_n, !(ram_we && ram_re))

endmodule
